// ===== src/xlsu_pkg.sv =====
// Shared types and constants for the x86 logic and shift unit.
package xlsu_pkg;

    // Instruction codes; codes twelve to fifteen are no-ops.
    typedef enum logic [3:0] {
        CMD_TEST = 4'd0,
        CMD_AND  = 4'd1,
        CMD_OR   = 4'd2,
        CMD_XOR  = 4'd3,
        CMD_NOT  = 4'd4,
        CMD_ROL  = 4'd5,
        CMD_ROR  = 4'd6,
        CMD_SAR  = 4'd7,
        CMD_SHL  = 4'd8,
        CMD_SHR  = 4'd9,
        CMD_SHLD = 4'd10,
        CMD_SHRD = 4'd11
    } cmd_t;

    // Operand size codes; code three acts as doubleword.
    localparam logic [1:0] WC_BYTE  = 2'd0;
    localparam logic [1:0] WC_WORD  = 2'd1;
    localparam logic [1:0] WC_DWORD = 2'd2;

    localparam int unsigned S_TDATA_W = 104;
    localparam int unsigned S_TUSER_W = 6;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned M_TUSER_W = 1;

    typedef struct packed {
        cmd_t        command;
        logic [1:0]  width_code;
        logic [31:0] dest_value;
        logic [31:0] src_value;
        logic [31:0] fill_value;
        logic        carry_in;
        logic        overflow_in;
        logic        zero_in;
        logic        sign_in;
    } op_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_back;
        logic        carry_out;
        logic        overflow_out;
        logic        zero_out;
        logic        sign_out;
    } res_t;

endpackage

// ===== src/xlsu_exec.sv =====
// Combinational execute logic: logic ops, rotates, shifts and double shifts.
module xlsu_exec (
    input  xlsu_pkg::op_t  op,
    output xlsu_pkg::res_t res
);

    function automatic logic msb_of(input logic [31:0] v, input logic [1:0] wc);
        case (wc)
            xlsu_pkg::WC_BYTE: msb_of = v[7];
            xlsu_pkg::WC_WORD: msb_of = v[15];
            default:           msb_of = v[31];
        endcase
    endfunction

    function automatic logic nxt_of(input logic [31:0] v, input logic [1:0] wc);
        case (wc)
            xlsu_pkg::WC_BYTE: nxt_of = v[6];
            xlsu_pkg::WC_WORD: nxt_of = v[14];
            default:           nxt_of = v[30];
        endcase
    endfunction

    logic [5:0]  bits;
    logic [31:0] mask;
    logic [31:0] dv;
    logic [31:0] fv;
    logic [31:0] rep;
    logic [4:0]  cnt;
    logic [4:0]  cnt_m1;
    logic [4:0]  rc;
    logic        cnt_lt;

    logic [63:0] rot_cat;
    logic [63:0] rot_lsh;
    logic [63:0] rot_rsh;
    logic [31:0] rot_res;

    logic        neg;
    logic [31:0] ext;
    logic [31:0] ext_sh1;
    logic [31:0] sar_full;
    logic [31:0] dv_sh1;
    logic [63:0] shl_wide;

    logic [63:0] dbl_l_cat;
    logic [63:0] dbl_l_sh;
    logic [31:0] dbl_l_res;
    logic [63:0] dbl_r_cat;
    logic [63:0] dbl_r_sh;

    logic [31:0] val;
    logic        wb;
    logic        cf;
    logic        of;
    logic        upd_zs;

    // Width selection and operand masking
    always_comb begin
        case (op.width_code)
            xlsu_pkg::WC_BYTE: begin
                bits = 6'd8;
                mask = 32'h0000_00ff;
                rep  = {4{op.dest_value[7:0]}};
                rc   = op.src_value[4:0] & 5'h07;
            end
            xlsu_pkg::WC_WORD: begin
                bits = 6'd16;
                mask = 32'h0000_ffff;
                rep  = {2{op.dest_value[15:0]}};
                rc   = op.src_value[4:0] & 5'h0f;
            end
            default: begin
                bits = 6'd32;
                mask = 32'hffff_ffff;
                rep  = op.dest_value;
                rc   = op.src_value[4:0];
            end
        endcase
    end

    assign dv     = op.dest_value & mask;
    assign fv     = op.fill_value & mask;
    assign cnt    = op.src_value[4:0];
    assign cnt_m1 = cnt - 5'd1;
    assign cnt_lt = {1'b0, cnt} < bits;

    // Rotate the replicated operand; the period keeps bits inside the width
    assign rot_cat = {rep, rep};
    assign rot_lsh = rot_cat << rc;
    assign rot_rsh = rot_cat >> rc;
    assign rot_res = ((op.command == xlsu_pkg::CMD_ROL) ? rot_lsh[63:32] : rot_rsh[31:0])
                     & mask;

    // Sign-extend for sar so bits past the width read as the sign
    assign neg      = msb_of(dv, op.width_code);
    assign ext      = neg ? (dv | ~mask) : dv;
    assign ext_sh1  = ext >> cnt_m1;
    assign sar_full = 32'($signed(ext) >>> cnt);
    assign dv_sh1   = dv >> cnt_m1;
    assign shl_wide = {32'd0, dv} << cnt;

    // Double shifts work on the pair placed side by side at the width
    assign dbl_l_cat = ({32'd0, dv} << bits) | {32'd0, fv};
    assign dbl_l_sh  = dbl_l_cat << cnt;
    assign dbl_r_cat = ({32'd0, fv} << bits) | {32'd0, dv};
    assign dbl_r_sh  = dbl_r_cat >> cnt;

    always_comb begin
        case (op.width_code)
            xlsu_pkg::WC_BYTE: dbl_l_res = {24'd0, dbl_l_sh[15:8]};
            xlsu_pkg::WC_WORD: dbl_l_res = {16'd0, dbl_l_sh[31:16]};
            default:           dbl_l_res = dbl_l_sh[63:32];
        endcase
    end

    always_comb begin
        val    = dv;
        wb     = 1'b1;
        cf     = op.carry_in;
        of     = op.overflow_in;
        upd_zs = 1'b0;
        case (op.command)
            xlsu_pkg::CMD_TEST, xlsu_pkg::CMD_AND: begin
                val    = dv & op.src_value;
                wb     = (op.command != xlsu_pkg::CMD_TEST);
                cf     = 1'b0;
                of     = 1'b0;
                upd_zs = 1'b1;
            end
            xlsu_pkg::CMD_OR: begin
                val    = dv | (op.src_value & mask);
                cf     = 1'b0;
                of     = 1'b0;
                upd_zs = 1'b1;
            end
            xlsu_pkg::CMD_XOR: begin
                val    = dv ^ (op.src_value & mask);
                cf     = 1'b0;
                of     = 1'b0;
                upd_zs = 1'b1;
            end
            xlsu_pkg::CMD_NOT: begin
                val = ~dv & mask;
            end
            xlsu_pkg::CMD_ROL, xlsu_pkg::CMD_ROR: begin
                // A count that is a multiple of the width changes nothing
                if (rc != 5'd0) begin
                    val = rot_res;
                    if (op.command == xlsu_pkg::CMD_ROL) begin
                        cf = rot_res[0];
                        if (rc == 5'd1) begin
                            of = msb_of(rot_res, op.width_code) ^ rot_res[0];
                        end
                    end else begin
                        cf = msb_of(rot_res, op.width_code);
                        if (rc == 5'd1) begin
                            of = msb_of(rot_res, op.width_code)
                                 ^ nxt_of(rot_res, op.width_code);
                        end
                    end
                end
            end
            xlsu_pkg::CMD_SAR: begin
                if (cnt != 5'd0) begin
                    val    = sar_full & mask;
                    cf     = ext_sh1[0];
                    of     = 1'b0;
                    upd_zs = 1'b1;
                end
            end
            xlsu_pkg::CMD_SHL: begin
                if (cnt != 5'd0) begin
                    val    = shl_wide[31:0] & mask;
                    cf     = shl_wide[bits];
                    of     = (cnt == 5'd1)
                             ? (msb_of(shl_wide[31:0], op.width_code) ^ shl_wide[bits])
                             : 1'b0;
                    upd_zs = 1'b1;
                end
            end
            xlsu_pkg::CMD_SHR: begin
                if (cnt != 5'd0) begin
                    val    = dv >> cnt;
                    cf     = dv_sh1[0];
                    of     = (cnt == 5'd1) ? msb_of(dv, op.width_code) : 1'b0;
                    upd_zs = 1'b1;
                end
            end
            xlsu_pkg::CMD_SHLD: begin
                if (cnt != 5'd0) begin
                    val    = dbl_l_res;
                    cf     = cnt_lt ? shl_wide[bits] : 1'b0;
                    if (cnt == 5'd1) begin
                        of = msb_of(dbl_l_res, op.width_code) ^ shl_wide[bits];
                    end
                    upd_zs = 1'b1;
                end
            end
            xlsu_pkg::CMD_SHRD: begin
                if (cnt != 5'd0) begin
                    val    = dbl_r_sh[31:0] & mask;
                    cf     = cnt_lt ? dv_sh1[0] : 1'b0;
                    if (cnt == 5'd1) begin
                        of = msb_of(dv ^ dbl_r_sh[31:0], op.width_code);
                    end
                    upd_zs = 1'b1;
                end
            end
            default: begin
                val = 32'd0;
                wb  = 1'b0;
            end
        endcase
    end

    always_comb begin
        res.result_value = val & mask;
        res.write_back   = wb;
        res.carry_out    = cf;
        res.overflow_out = of;
        res.zero_out     = upd_zs ? ((val & mask) == 32'd0) : op.zero_in;
        res.sign_out     = upd_zs ? msb_of(val & mask, op.width_code) : op.sign_in;
    end

endmodule

// ===== src/x86_logic_shift_unit.sv =====
// Top level: input register, execute logic and output register on stream channels.
// An input transfer loads the input register; the execute logic then feeds the output
// register, from which the result leaves when m_axis_tready is high.
// Throughput: one instruction per cycle while the output does not stall; the execute logic
// is a single pass of barrel shifters and masks between the input and output registers.
// Back-pressure reaches s_axis_tready only when both registers are full and the output stalls.
// Reset (aresetn low at a clock edge) empties both stages; the payload registers have no reset.
module x86_logic_shift_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] dest_value, [63:32] src_value, [95:64] fill_value, [96] carry_in,
    // [97] overflow_in, [98] zero_in, [99] sign_in, [103:100] zero
    input  logic [xlsu_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [3:0] command, [5:4] width_code
    input  logic [xlsu_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] result_value, [32] carry_out, [33] overflow_out, [34] zero_out,
    // [35] sign_out, [39:36] zero
    output logic [xlsu_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] write_back
    output logic [xlsu_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    xlsu_pkg::op_t   s1_op_reg;
    xlsu_pkg::op_t   s1_op_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    xlsu_pkg::res_t  m_res_reg;
    xlsu_pkg::res_t  m_res_next;
    xlsu_pkg::res_t  exec_res;
    logic            out_free;
    logic            s1_adv;
    logic            in_xfer;

    // The output slot is free when empty or when its result leaves this cycle
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Unpack the incoming transfer
    always_comb begin
        s1_op_next.command     = xlsu_pkg::cmd_t'(s_axis_tuser[3:0]);
        s1_op_next.width_code  = s_axis_tuser[5:4];
        s1_op_next.dest_value  = s_axis_tdata[31:0];
        s1_op_next.src_value   = s_axis_tdata[63:32];
        s1_op_next.fill_value  = s_axis_tdata[95:64];
        s1_op_next.carry_in    = s_axis_tdata[96];
        s1_op_next.overflow_in = s_axis_tdata[97];
        s1_op_next.zero_in     = s_axis_tdata[98];
        s1_op_next.sign_in     = s_axis_tdata[99];
    end

    xlsu_exec u_exec (
        .op  (s1_op_reg),
        .res (exec_res)
    );

    // Stage control: load on transfer, drop when the next stage takes the item
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
            m_res_next   = exec_res;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers advance without reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_op_reg <= s1_op_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_res_reg.sign_out, m_res_reg.zero_out,
                            m_res_reg.overflow_out, m_res_reg.carry_out,
                            m_res_reg.result_value};
    assign m_axis_tuser  = m_res_reg.write_back;

    // An accepted item occupies the input register in the next cycle
    a_in_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> s1_valid_reg)
        else $error("accepted item missing from input register");

    // An item that advances shows up on the output in the next cycle
    a_adv_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_axis_tvalid)
        else $error("advanced item missing from output register");

    // A new result appears only after an item sat in the input register
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg))
        else $error("result without a source item");

    // A held input item is not lost while the output stalls
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_op_reg))
        else $error("stalled input item lost");

endmodule
